// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: design/rsc_pkg.sv
// Shared types and constants of the record stream checker.
package rsc_pkg;

   localparam int TYPE_W  = 15;
   localparam int LEN_W   = 16;
   localparam int COUNT_W = 15;

   // Input operation codes.
   typedef enum logic [1:0] {
      OP_DATA    = 2'd0,
      OP_CLOSE   = 2'd1,
      OP_RESTART = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   // Message status codes.
   typedef enum logic [1:0] {
      ST_PROGRESS = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_INVALID  = 2'd2,
      ST_TOOLONG  = 2'd3
   } status_type;

   // Register word index of the end record type.
   localparam logic CSR_END_TYPE = 1'b0;

   // One result beat.
   typedef struct packed {
      status_type         status;
      logic               header_ready;
      logic               rec_critical;
      logic [TYPE_W-1:0]  rec_type;
      logic [LEN_W-1:0]   rec_body_length;
      logic [COUNT_W-1:0] byte_count;
   } result_type;

endpackage

// File: design/rsc_parser.sv
// Record parser: message state and the per-beat update that produces one result.
module rsc_parser #(
   parameter int MAX_MESSAGE_BYTES = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [1:0]                op,
   input  logic [7:0]                data_byte,
   input  logic [rsc_pkg::TYPE_W-1:0] end_type,
   output rsc_pkg::result_type       result
);
   import rsc_pkg::*;

   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE_BYTES);

   logic [2:0]        hdr_index_ff, hdr_index_in;
   logic [23:0]       hdr_bytes_ff, hdr_bytes_in;
   logic [LEN_W-1:0]  body_rem_ff, body_rem_in;
   logic              last_end_ff, last_end_in;
   logic              end_seen_ff, end_seen_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        sticky_ff, sticky_in;
   logic [LEN_W-1:0]  body_dec;
   logic              complete_now;

   assign complete_now = (hdr_index_ff == 3'd0) && (count_ff != '0) && last_end_ff;
   assign body_dec     = (body_rem_ff != '0) ? body_rem_ff - LEN_W'(1) : body_rem_ff;

   // Next state and result for the beat being processed.
   always_comb begin
      hdr_index_in = hdr_index_ff;
      hdr_bytes_in = hdr_bytes_ff;
      body_rem_in  = body_rem_ff;
      last_end_in  = last_end_ff;
      end_seen_in  = end_seen_ff;
      count_in     = count_ff;
      sticky_in    = sticky_ff;
      result       = '0;
      case (op_type'(op))
         OP_RESTART: begin
            hdr_index_in = '0;
            hdr_bytes_in = '0;
            body_rem_in  = '0;
            last_end_in  = 1'b0;
            end_seen_in  = 1'b0;
            count_in     = '0;
            sticky_in    = ST_PROGRESS;
         end
         OP_CLOSE: begin
            if (sticky_ff == ST_PROGRESS && !complete_now) begin
               sticky_in = ST_INVALID;
            end
         end
         OP_DATA: begin
            if (sticky_ff == ST_PROGRESS) begin
               if (count_ff >= CNT_MAX) begin
                  sticky_in = ST_TOOLONG;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  if (hdr_index_ff < 3'd3) begin
                     hdr_bytes_in = {hdr_bytes_ff[15:0], data_byte};
                     hdr_index_in = hdr_index_ff + 3'd1;
                  end else if (hdr_index_ff == 3'd3) begin
                     // Last header byte: report the header and enter the body, if it has one.
                     result.header_ready    = 1'b1;
                     result.rec_critical    = hdr_bytes_ff[23];
                     result.rec_type        = hdr_bytes_ff[22:8];
                     result.rec_body_length = {hdr_bytes_ff[7:0], data_byte};
                     hdr_bytes_in = '0;
                     last_end_in  = (hdr_bytes_ff[22:8] == end_type);
                     body_rem_in  = {hdr_bytes_ff[7:0], data_byte};
                     if ({hdr_bytes_ff[7:0], data_byte} == '0) begin
                        hdr_index_in = 3'd0;
                        if (last_end_in) begin
                           if (!hdr_bytes_ff[23] || end_seen_ff) begin
                              sticky_in = ST_INVALID;
                           end else begin
                              end_seen_in = 1'b1;
                           end
                        end
                     end else begin
                        hdr_index_in = 3'd4;
                     end
                  end else begin
                     // Body byte; an end record may not carry a body.
                     body_rem_in = body_dec;
                     if (body_dec == '0) begin
                        hdr_index_in = 3'd0;
                        if (last_end_ff) begin
                           sticky_in = ST_INVALID;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      // Status follows the updated state.
      if (sticky_in != ST_PROGRESS) begin
         result.status = sticky_in;
      end else if (hdr_index_in == 3'd0 && count_in != '0 && last_end_in) begin
         result.status = ST_COMPLETE;
      end else begin
         result.status = ST_PROGRESS;
      end
      result.byte_count = COUNT_W'(count_in);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_index_ff <= '0;
         hdr_bytes_ff <= '0;
         body_rem_ff  <= '0;
         last_end_ff  <= 1'b0;
         end_seen_ff  <= 1'b0;
         count_ff     <= '0;
         sticky_ff    <= ST_PROGRESS;
      end else if (step) begin
         hdr_index_ff <= hdr_index_in;
         hdr_bytes_ff <= hdr_bytes_in;
         body_rem_ff  <= body_rem_in;
         last_end_ff  <= last_end_in;
         end_seen_ff  <= end_seen_in;
         count_ff     <= count_in;
         sticky_ff    <= sticky_in;
      end
   end

endmodule

// File: design/rsc_csr.sv
// Configuration register block: holds the end record type.
module rsc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [rsc_pkg::TYPE_W-1:0] end_type
);
   import rsc_pkg::*;

   logic [TYPE_W-1:0] end_type_ff;
   logic              wr_en;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite && (paddr[2] == CSR_END_TYPE);
   assign end_type = end_type_ff;

   // Register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         end_type_ff <= '0;
      end else if (wr_en) begin
         end_type_ff <= pwdata[TYPE_W-1:0];
      end
   end

   // Read decode; addresses past the register list read as zero.
   always_comb begin
      unique case (paddr[2])
         CSR_END_TYPE: prdata = {{(32-TYPE_W){1'b0}}, end_type_ff};
         default:      prdata = '0;
      endcase
   end

endmodule

// File: design/ke_record_stream_checker_top.sv
// Top level of the record stream checker: input stage, parser and result stage.
//
// The req channel carries one beat per received message byte or command:
// op 0 is a data byte, op 1 says the peer closed the stream, op 2 starts a
// new message. Each req beat yields exactly one rsp beat with the message
// status, the header just finished (if any) and the running byte count.
// A beat accepted is registered in the input stage, then processed by the
// parser into the result stage, from which its result is offered. The parser
// state updates once per beat, so one beat per cycle is sustained while the
// receiver takes results. When the receiver stalls, the result stage holds
// its beat and the input stage fills; req_ready drops only when both are
// full. Reset empties both stages and clears the message state and the end
// record type. The user must write the end record type over the register
// port only while no beat is in flight, which the block does not enforce.
module ke_record_stream_checker_top #(
   parameter int MAX_MESSAGE_BYTES = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_header_ready,
   output logic                        rsp_rec_critical,
   output logic [rsc_pkg::TYPE_W-1:0]  rsp_rec_type,
   output logic [rsc_pkg::LEN_W-1:0]   rsp_rec_body_length,
   output logic [rsc_pkg::COUNT_W-1:0] rsp_byte_count,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rsc_pkg::*;

   logic              in_valid_ff;
   logic [1:0]        in_op_ff;
   logic [7:0]        in_byte_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   result_type        result;
   logic              out_adv;
   logic              step;
   logic [TYPE_W-1:0] end_type;

   assign out_adv   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_adv;
   assign req_ready = !in_valid_ff || out_adv;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
   end

   rsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .end_type (end_type)
   );

   rsc_parser #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .op        (in_op_ff),
      .data_byte (in_byte_ff),
      .end_type  (end_type),
      .result    (result)
   );

   // Result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_header_ready    = out_ff.header_ready;
   assign rsp_rec_critical    = out_ff.rec_critical;
   assign rsp_rec_type        = out_ff.rec_type;
   assign rsp_rec_body_length = out_ff.rec_body_length;
   assign rsp_byte_count      = out_ff.byte_count;

endmodule

// File: design/rsc_checker.sv
// Port-level assertions for the record stream checker and their bind.
`include "assert_macros.svh"

module rsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic                        rsp_header_ready,
   input logic                        rsp_rec_critical,
   input logic [rsc_pkg::TYPE_W-1:0]  rsp_rec_type,
   input logic [rsc_pkg::LEN_W-1:0]   rsp_rec_body_length,
   input logic [rsc_pkg::COUNT_W-1:0] rsp_byte_count
);
   import rsc_pkg::*;

   // Reset empties the result stage.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A stalled result beat holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_byte_count))

   // Header fields are zero on beats that finish no header.
   `ASSERT_SAME(a_hdr_zero, clock, reset, rsp_valid && !rsp_header_ready, !rsp_rec_critical && rsp_rec_type == '0 && rsp_rec_body_length == '0)

   // A finished header means the byte was taken, so the count was below its maximum.
   `ASSERT_SAME(a_hdr_not_long, clock, reset, rsp_valid && rsp_header_ready, rsp_status != ST_TOOLONG)

endmodule

bind ke_record_stream_checker_top rsc_checker u_rsc_checker (.*);
